/* rtl/ucal_pkg.sv */
package ucal_pkg;

	// field widths
	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// internal widths: day count since epoch, second of day, minute of day
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned TOD_W   = 17;
	localparam int unsigned MINS_W  = 11;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned A1_W    = 16;
	localparam int unsigned CENT_W  = 7;

	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned SECS_PER_MIN = 60;
	localparam int unsigned MINS_PER_HR  = 60;
	localparam int unsigned DAYS_PER_4Y  = 1461;

	// reciprocals for constant division: q = (x * RECIP) >> SHIFT
	// seconds / 86400 = (t >> 7) / 675
	localparam int unsigned DAY_PRESHIFT = 7;
	localparam longint unsigned DAY_RECIP = 64'd50903317;
	localparam int unsigned DAY_SHIFT    = 35;
	// tod / 3600 = (tod >> 4) / 225
	localparam int unsigned HOUR_PRESHIFT = 4;
	localparam int unsigned HOUR_RECIP    = 9321;
	localparam int unsigned HOUR_SHIFT    = 21;
	// tod / 60 = (tod >> 2) / 15
	localparam int unsigned MINS_PRESHIFT = 2;
	localparam int unsigned MINS_RECIP    = 34953;
	localparam int unsigned MINS_SHIFT    = 19;
	// (4a + 3) / 1461
	localparam int unsigned CENT_RECIP = 367469;
	localparam int unsigned CENT_SHIFT = 29;

	// century selection over the 32-bit range: centuries that start
	// in March 1900, 2000 and 2100
	localparam int unsigned ERA2000_START = 11017;
	localparam int unsigned ERA2100_START = 47541;
	localparam int unsigned ERA1900_OFS   = 25508;
	localparam int unsigned BASE_1900     = 1900;
	localparam int unsigned BASE_2000     = 2000;
	localparam int unsigned BASE_2100     = 2100;

	// 1970-01-01 was a Thursday
	localparam int unsigned WDAY_EPOCH = 3;
	localparam int unsigned DAYS_PER_WK = 7;

	// months counted from March
	localparam int unsigned NUM_MONTHS = 12;
	localparam int unsigned JAN_IDX    = 10;
	localparam int unsigned MARCH      = 3;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} ucal_ld_t;

	// first day of month k within a March-based year
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] k);
		logic [DOY_W-1:0] r;
		case (k)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd366;
		endcase
		return r;
	endfunction

endpackage

/* rtl/ucal_in_if.sv */
interface ucal_in_if import ucal_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

/* rtl/ucal_out_if.sv */
interface ucal_out_if import ucal_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day_of_month;
	logic [WDAY_W-1:0]  weekday;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, output hour, output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input weekday, input hour, input minute, input second, output ready);
endinterface

/* rtl/ucal_ctrl.sv */
module ucal_ctrl import ucal_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	output logic     in_ready,
	output logic     out_valid,
	output ucal_ld_t ld
);

	localparam int unsigned NSTG = 6;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;
	logic [NSTG:0]   vld_in;

	// a stage moves when it is empty or its successor moves, so bubbles collapse
	always_comb begin
		adv[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign vld_in = {vld_q, in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	assign ld = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};
	assign in_ready  = adv[1];
	assign out_valid = vld_q[NSTG];

endmodule

/* rtl/ucal_tod.sv */
module ucal_tod import ucal_pkg::*; (
	input  logic              clk,
	input  ucal_ld_t          ld,
	input  logic [TOD_W-1:0]  t_lo,
	input  logic [DAYS_W-1:0] days,
	output logic [HOUR_W-1:0] hour,
	output logic [MIN_W-1:0]  minute,
	output logic [SEC_W-1:0]  second
);

	localparam int unsigned BASE_W = DAYS_W + TOD_W;
	localparam int unsigned HX_W   = TOD_W - HOUR_PRESHIFT;
	localparam int unsigned HP_W   = HX_W + 14;
	localparam int unsigned MX_W   = TOD_W - MINS_PRESHIFT;
	localparam int unsigned MP_W   = MX_W + 16;

	logic [BASE_W-1:0] day_base;
	logic [TOD_W-1:0]  tod;
	logic [TOD_W-1:0]  tod_s3, tod_s4;
	logic [HP_W-1:0]   hour_prod;
	logic [MP_W-1:0]   mins_prod;
	logic [HOUR_W-1:0] hour_s4, hour_s5, hour_s6;
	logic [MINS_W-1:0] mins_s4;
	logic [MINS_W-1:0] minute_full;
	logic [TOD_W-1:0]  second_full;
	logic [MIN_W-1:0]  minute_s5, minute_s6;
	logic [SEC_W-1:0]  second_s5, second_s6;

	// second of day; result is below 2^17 so the low bits suffice
	assign day_base = BASE_W'(days) * BASE_W'(SECS_PER_DAY);
	assign tod      = t_lo - day_base[TOD_W-1:0];

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			tod_s3 <= tod;
		end
	end

	assign hour_prod = HP_W'(tod_s3[TOD_W-1:HOUR_PRESHIFT]) * HP_W'(HOUR_RECIP);
	assign mins_prod = MP_W'(tod_s3[TOD_W-1:MINS_PRESHIFT]) * MP_W'(MINS_RECIP);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			tod_s4  <= tod_s3;
			hour_s4 <= hour_prod[HOUR_SHIFT +: HOUR_W];
			mins_s4 <= mins_prod[MINS_SHIFT +: MINS_W];
		end
	end

	assign minute_full = mins_s4 - MINS_W'(MINS_W'(hour_s4) * MINS_W'(MINS_PER_HR));
	assign second_full = tod_s4 - TOD_W'(TOD_W'(mins_s4) * TOD_W'(SECS_PER_MIN));

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			hour_s5   <= hour_s4;
			minute_s5 <= minute_full[MIN_W-1:0];
			second_s5 <= second_full[SEC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			second_s6 <= second_s5;
		end
	end

	assign hour   = hour_s6;
	assign minute = minute_s6;
	assign second = second_s6;

endmodule

/* rtl/ucal_date.sv */
module ucal_date import ucal_pkg::*; (
	input  logic               clk,
	input  ucal_ld_t           ld,
	input  logic [DAYS_W-1:0]  days,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DAY_W-1:0]   day_of_month,
	output logic [WDAY_W-1:0]  weekday
);

	localparam int unsigned WX_W = 18;
	localparam int unsigned CX_W = A1_W + 2;
	localparam int unsigned CP_W = CX_W + 19;
	localparam int unsigned QP_W = 18;

	logic [A1_W-1:0]    a1;
	logic [YEAR_W-1:0]  base;
	logic [WX_W-1:0]    wx;
	logic [5:0]         wsum;
	logic [3:0]         wfold;
	logic [WDAY_W-1:0]  wd;
	logic [A1_W-1:0]    a1_s3, a1_s4;
	logic [YEAR_W-1:0]  base_s3, base_s4;
	logic [WDAY_W-1:0]  wd_s3, wd_s4, wd_s5, wd_s6;
	logic [CP_W-1:0]    cent_prod;
	logic [CENT_W-1:0]  c_s4;
	logic [QP_W-1:0]    quad_days;
	logic [A1_W-1:0]    a2_full;
	logic [DOY_W-1:0]   a2_s5;
	logic [YEAR_W-1:0]  yr_s5;
	logic [MONTH_W-1:0] d;
	logic               late;
	logic [DOY_W-1:0]   dom_full;
	logic [YEAR_W-1:0]  year_s6;
	logic [MONTH_W-1:0] month_s6;
	logic [DAY_W-1:0]   dom_s6;

	// pick the century and the day within it
	always_comb begin
		if (days >= DAYS_W'(ERA2100_START)) begin
			a1   = days - A1_W'(ERA2100_START);
			base = YEAR_W'(BASE_2100);
		end else if (days >= DAYS_W'(ERA2000_START)) begin
			a1   = days - A1_W'(ERA2000_START);
			base = YEAR_W'(BASE_2000);
		end else begin
			a1   = days + A1_W'(ERA1900_OFS);
			base = YEAR_W'(BASE_1900);
		end
	end

	// mod 7 by folding octal digits, since 8 = 1 mod 7
	assign wx    = WX_W'(days) + WX_W'(WDAY_EPOCH);
	assign wsum  = 6'(wx[2:0]) + 6'(wx[5:3]) + 6'(wx[8:6]) + 6'(wx[11:9])
		+ 6'(wx[14:12]) + 6'(wx[17:15]);
	assign wfold = 4'(wsum[5:3]) + 4'(wsum[2:0]);
	assign wd    = (wfold >= 4'(DAYS_PER_WK)) ? WDAY_W'(wfold - 4'(DAYS_PER_WK))
		: wfold[WDAY_W-1:0];

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			a1_s3   <= a1;
			base_s3 <= base;
			wd_s3   <= wd;
		end
	end

	assign cent_prod = CP_W'({a1_s3, 2'b11}) * CP_W'(CENT_RECIP);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			a1_s4   <= a1_s3;
			base_s4 <= base_s3;
			wd_s4   <= wd_s3;
			c_s4    <= cent_prod[CENT_SHIFT +: CENT_W];
		end
	end

	assign quad_days = QP_W'(c_s4) * QP_W'(DAYS_PER_4Y);
	assign a2_full   = a1_s4 - quad_days[QP_W-1:2];

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			a2_s5 <= a2_full[DOY_W-1:0];
			yr_s5 <= base_s4 + YEAR_W'(c_s4);
			wd_s5 <= wd_s4;
		end
	end

	// month index from March: count month starts at or before the day
	always_comb begin
		d = '0;
		for (int k = 1; k < NUM_MONTHS; k++) begin
			if (month_start(MONTH_W'(k)) <= a2_s5) begin
				d = d + 4'd1;
			end
		end
	end

	assign late     = (d >= MONTH_W'(JAN_IDX));
	assign dom_full = a2_s5 - month_start(d) + 9'd1;

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			year_s6  <= yr_s5 + YEAR_W'(late);
			month_s6 <= late ? (d - MONTH_W'(JAN_IDX - 1)) : (d + MONTH_W'(MARCH));
			dom_s6   <= dom_full[DAY_W-1:0];
			wd_s6    <= wd_s5;
		end
	end

	assign year         = year_s6;
	assign month        = month_s6;
	assign day_of_month = dom_s6;
	assign weekday      = wd_s6;

endmodule

/* rtl/unix_seconds_to_calendar.sv */
// An input transfer is registered in stage s1 and passes through s2 to s6, the output register;
// the result is offered once it reaches s6 and transfers when calendar.ready is high.
// One timestamp per cycle unless the output stalls; a six-stage pipeline, at most one multiply deep per stage.
// Each stage advances when empty or when its successor advances, so inputs are
// still taken while a result waits, until every stage is full.
// Reset clears only the stage valid bits; no clearing pass.
module unix_seconds_to_calendar import ucal_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ucal_in_if.sink       timestamp,
	ucal_out_if.source    calendar
);

	localparam int unsigned DX_W = EPOCH_W - DAY_PRESHIFT;
	localparam int unsigned DP_W = DX_W + 26;

	ucal_ld_t            ld;
	logic [EPOCH_W-1:0]  t_s1;
	logic [DP_W-1:0]     days_prod;
	logic [TOD_W-1:0]    t_lo_s2;
	logic [DAYS_W-1:0]   days_s2;

	ucal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (timestamp.valid),
		.out_ready (calendar.ready),
		.in_ready  (timestamp.ready),
		.out_valid (calendar.valid),
		.ld        (ld)
	);

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			t_s1 <= timestamp.epoch_seconds;
		end
	end

	// whole days since epoch
	assign days_prod = DP_W'(t_s1[EPOCH_W-1:DAY_PRESHIFT]) * DP_W'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			t_lo_s2 <= t_s1[TOD_W-1:0];
			days_s2 <= days_prod[DAY_SHIFT +: DAYS_W];
		end
	end

	ucal_tod u_tod (
		.clk    (clk),
		.ld     (ld),
		.t_lo   (t_lo_s2),
		.days   (days_s2),
		.hour   (calendar.hour),
		.minute (calendar.minute),
		.second (calendar.second)
	);

	ucal_date u_date (
		.clk          (clk),
		.ld           (ld),
		.days         (days_s2),
		.year         (calendar.year),
		.month        (calendar.month),
		.day_of_month (calendar.day_of_month),
		.weekday      (calendar.weekday)
	);

	// a waiting result must not be overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid && !calendar.ready |-> !ld.s6)
		else $error("output register loaded while result stalled");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.month >= 4'd1 && calendar.month <= 4'd12
			&& calendar.day_of_month >= 5'd1 && calendar.weekday <= 3'd6
			&& calendar.year >= 12'd1970 && calendar.year <= 12'd2106))
		else $error("date field out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.hour <= 5'd23 && calendar.minute <= 6'd59
			&& calendar.second <= 6'd59))
		else $error("time field out of range");

	// an empty output stage never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!calendar.valid |-> ld.s6)
		else $error("empty output stage not advancing");

endmodule
